// ----- rtl/core/efsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Earliest-free server assigner package
// Shared widths, request codes, word types, the scan control type and the state type.
// ----------------------------------------------------------------------------
package efsa_pkg;

  localparam int DEF_MAX_SERVERS = 64;
  localparam int DEF_LOAD_WIDTH  = 32;

  localparam int SVC_WIDTH = 32;
  localparam int SRV_WIDTH = 7;
  localparam int ACT_WIDTH = 7;

  localparam logic REQ_CLEAR = 1'b0;
  localparam logic REQ_JOB   = 1'b1;

  typedef struct packed {
    logic                 req_type;
    logic [SVC_WIDTH-1:0] service_time;
  } in_word_t;

  typedef struct packed {
    logic [SRV_WIDTH-1:0] next_server;
    logic [SVC_WIDTH-1:0] next_load;
  } out_word_t;

  // Control part of the scan word that walks down the row of cells.
  typedef struct packed {
    logic valid;
    logic clear;
    logic add;
    logic report;
  } tok_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

// ----- rtl/core/efsa_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Earliest-free server assigner cell
// Holds one server load, applies a clear or a job add as the scan word passes,
// and forwards the running minimum to the next cell.
// ----------------------------------------------------------------------------
module efsa_cell
  import efsa_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int IDX_W      = 6,
  parameter int CNT_W      = 7,
  parameter int LOAD_WIDTH = DEF_LOAD_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CNT_W-1:0]      act_cnt,
  input  tok_ctl_t              prev_ctl,
  input  logic [SVC_WIDTH-1:0]  prev_svc,
  input  logic [IDX_W-1:0]      prev_add_idx,
  input  logic [LOAD_WIDTH-1:0] prev_best_load,
  input  logic [IDX_W-1:0]      prev_best_idx,
  output tok_ctl_t              next_ctl,
  output logic [SVC_WIDTH-1:0]  next_svc,
  output logic [IDX_W-1:0]      next_add_idx,
  output logic [LOAD_WIDTH-1:0] next_best_load,
  output logic [IDX_W-1:0]      next_best_idx
);

  localparam int SUMW = ((LOAD_WIDTH > SVC_WIDTH) ? LOAD_WIDTH : SVC_WIDTH) + 1;
  localparam logic [SUMW-1:0] SUM_MAX = SUMW'({LOAD_WIDTH{1'b1}});

  logic [LOAD_WIDTH-1:0] load;
  logic [LOAD_WIDTH-1:0] load_next;
  logic [SUMW-1:0]       sum;
  logic                  is_act;
  logic                  take;

  always_comb begin
    sum       = SUMW'(load) + SUMW'(prev_svc);
    load_next = load;
    if (prev_ctl.valid) begin
      if (prev_ctl.clear) begin
        load_next = '0;
      end else if (prev_ctl.add && (prev_add_idx == IDX_W'(INDEX))) begin
        load_next = (sum > SUM_MAX) ? {LOAD_WIDTH{1'b1}} : sum[LOAD_WIDTH-1:0];
      end
    end
    is_act = (CNT_W'(INDEX) < act_cnt);
    take   = is_act && ((INDEX == 0) || (load_next < prev_best_load));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load     <= '0;
      next_ctl <= '0;
    end else begin
      load     <= load_next;
      next_ctl <= prev_ctl;
    end
  end

  always_ff @(posedge clk) begin
    next_svc       <= prev_svc;
    next_add_idx   <= prev_add_idx;
    next_best_load <= take ? load_next : prev_best_load;
    next_best_idx  <= take ? IDX_W'(INDEX) : prev_best_idx;
  end

endmodule

// ----- rtl/core/earliest_free_server_assigner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Earliest-free server assigner
// Greedy list scheduling over a row of load cells with a cached least-loaded
// server.
// ----------------------------------------------------------------------------
// Each accepted word sends one scan word down a row of MAX_SERVERS cells, one
// cell per cycle. Its result is held as pending, then moved into the output
// register; a new word is taken only once the last result has left for the
// output register, so no word is taken while a scan runs. A clear word zeroes
// every load. A job goes to the cached least-loaded server, that cell adds
// the service time as the scan passes, and the scan returns the new
// least-loaded server. A write to active_servers starts the same scan to
// refresh the cached choice, and in that time no input word is taken. The
// output register lets the next word be accepted while a result still waits.
module earliest_free_server_assigner
  import efsa_pkg::*;
#(
  parameter int MAX_SERVERS = DEF_MAX_SERVERS,
  parameter int LOAD_WIDTH  = DEF_LOAD_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [ACT_WIDTH-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word
);

  localparam int IDX_W = $clog2(MAX_SERVERS);
  localparam int CNT_RAW = $clog2(MAX_SERVERS + 1);
  localparam int CNT_W = (CNT_RAW > ACT_WIDTH) ? CNT_RAW : ACT_WIDTH;

  state_t                state;
  state_t                state_next;
  logic [ACT_WIDTH-1:0]  active_servers;
  logic [CNT_W-1:0]      act_ext;
  logic [CNT_W-1:0]      act_cnt;
  logic                  rescan_needed;
  logic                  emit_pending;
  logic                  in_fire;
  logic                  launch_item;
  logic                  launch_rescan;
  logic [IDX_W-1:0]      best_idx;
  logic [LOAD_WIDTH-1:0] best_load;
  logic [IDX_W:0]        srv_num;
  logic [SVC_WIDTH-1:0]  load_field;

  tok_ctl_t              head_ctl;
  logic [SVC_WIDTH-1:0]  head_svc;
  logic [IDX_W-1:0]      head_add_idx;

  tok_ctl_t              lk_ctl      [MAX_SERVERS+1];
  logic [SVC_WIDTH-1:0]  lk_svc      [MAX_SERVERS+1];
  logic [IDX_W-1:0]      lk_add_idx  [MAX_SERVERS+1];
  logic [LOAD_WIDTH-1:0] lk_best_load[MAX_SERVERS+1];
  logic [IDX_W-1:0]      lk_best_idx [MAX_SERVERS+1];

  tok_ctl_t              tail_ctl;

  always_comb begin
    act_ext = CNT_W'(active_servers);
    if (act_ext == '0) begin
      act_cnt = CNT_W'(1);
    end else if (act_ext > CNT_W'(MAX_SERVERS)) begin
      act_cnt = CNT_W'(MAX_SERVERS);
    end else begin
      act_cnt = act_ext;
    end
  end

  assign lk_ctl[0]       = head_ctl;
  assign lk_svc[0]       = head_svc;
  assign lk_add_idx[0]   = head_add_idx;
  assign lk_best_load[0] = '0;
  assign lk_best_idx[0]  = '0;

  for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_cell
    efsa_cell #(
      .INDEX     (g),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W),
      .LOAD_WIDTH(LOAD_WIDTH)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .act_cnt       (act_cnt),
      .prev_ctl      (lk_ctl[g]),
      .prev_svc      (lk_svc[g]),
      .prev_add_idx  (lk_add_idx[g]),
      .prev_best_load(lk_best_load[g]),
      .prev_best_idx (lk_best_idx[g]),
      .next_ctl      (lk_ctl[g+1]),
      .next_svc      (lk_svc[g+1]),
      .next_add_idx  (lk_add_idx[g+1]),
      .next_best_load(lk_best_load[g+1]),
      .next_best_idx (lk_best_idx[g+1])
    );
  end

  assign tail_ctl = lk_ctl[MAX_SERVERS];

  assign in_stall = !((state == ST_IDLE) && !emit_pending && !rescan_needed);
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    launch_item   = 1'b0;
    launch_rescan = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          launch_item = 1'b1;
          state_next  = ST_SCAN;
        end else if (rescan_needed && !emit_pending) begin
          launch_rescan = 1'b1;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail_ctl.valid) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ctl <= '0;
    end else begin
      head_ctl.valid  <= launch_item || launch_rescan;
      head_ctl.clear  <= launch_item && (in_word.req_type == REQ_CLEAR);
      head_ctl.add    <= launch_item && (in_word.req_type == REQ_JOB);
      head_ctl.report <= launch_item;
    end
  end

  always_ff @(posedge clk) begin
    head_svc     <= in_word.service_time;
    head_add_idx <= best_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_servers <= ACT_WIDTH'(1);
      rescan_needed  <= 1'b0;
      best_idx       <= '0;
      best_load      <= '0;
      emit_pending   <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        active_servers <= cfg_data;
        rescan_needed  <= 1'b1;
      end else if (launch_rescan) begin
        rescan_needed <= 1'b0;
      end
      if (tail_ctl.valid) begin
        best_idx  <= lk_best_idx[MAX_SERVERS];
        best_load <= lk_best_load[MAX_SERVERS];
      end
      if (tail_ctl.valid && tail_ctl.report) begin
        emit_pending <= 1'b1;
      end else if (emit_pending && (!out_valid || !out_stall)) begin
        emit_pending <= 1'b0;
      end
      if (emit_pending && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign srv_num = {1'b0, best_idx} + {{IDX_W{1'b0}}, 1'b1};

  if (LOAD_WIDTH > SVC_WIDTH) begin : g_load_sat
    assign load_field = (best_load[LOAD_WIDTH-1:SVC_WIDTH] != '0) ?
                        {SVC_WIDTH{1'b1}} : best_load[SVC_WIDTH-1:0];
  end else begin : g_load_ext
    assign load_field = SVC_WIDTH'(best_load);
  end

  always_ff @(posedge clk) begin
    if (emit_pending && (!out_valid || !out_stall)) begin
      out_word.next_server <= SRV_WIDTH'(srv_num);
      out_word.next_load   <= load_field;
    end
  end

  a_tail_in_scan : assert property (@(posedge clk) disable iff (rst)
    tail_ctl.valid |-> (state == ST_SCAN))
    else $error("Scan word left the row while no scan was running.");

  a_no_emit_in_scan : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !emit_pending)
    else $error("A result waited while a scan was running.");

  a_out_from_emit : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(emit_pending))
    else $error("Output word appeared without a finished scan.");

endmodule
